// File: hdl/bpc_pkg.sv
// ============================================================================
// bpc_pkg: shared types and constants for the barometric compensation block
// Holds register indexes, fixed coefficients and the front-to-back queue entry.
// ============================================================================
`default_nettype none

package bpc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_OSS    = 3'd0;
    localparam logic [2:0] REG_AC123  = 3'd1;
    localparam logic [2:0] REG_AC456  = 3'd2;
    localparam logic [2:0] REG_B12    = 3'd3;
    localparam logic [2:0] REG_MCMD   = 3'd4;

    // Fixed constants of the published compensation.
    localparam logic [31:0] C_B6_OFS  = 32'd4000;
    localparam logic [31:0] C_SCALE   = 32'd50000;
    localparam logic [31:0] C_P_K1    = 32'd3038;
    localparam logic [31:0] C_P_K2    = 32'hFFFF_E343; // -7357
    localparam logic [31:0] C_P_K3    = 32'd3791;
    localparam logic [31:0] C_HALF    = 32'd32768;

    // One raw item as it waits between front and back.
    typedef struct packed {
        logic [15:0] ut;
        logic [18:0] up;
    } item_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATH,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: hdl/bpc_div.sv
// ============================================================================
// bpc_div: unsigned 32-bit restoring divider
// Produces one quotient bit per cycle.
// ============================================================================
`default_nettype none

module bpc_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // One shift-and-subtract step per cycle.
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[31]} - {1'b0, d_reg};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[32]) begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end else begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// File: hdl/bpc_front.sv
// ============================================================================
// bpc_front: input acceptance and two-entry item queue
// Takes raw items and holds them until the back end is free.
// ============================================================================
`default_nettype none

module bpc_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire bpc_pkg::item_t in_item,
    output logic                q_valid,
    input  wire logic           q_pop,
    output bpc_pkg::item_t      q_item
);

    bpc_pkg::item_t mem_reg [2];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    // Pointer and fill count update.
    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    // The queue never overfills and is never popped empty.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !q_pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");

endmodule

`default_nettype wire

// File: hdl/bpc_back.sv
// ============================================================================
// bpc_back: compensation sequencer
// Steps the published integer arithmetic, one multiply or add per cycle while
// not stalled, with both general divisions done on the shared serial divider.
// ============================================================================
`default_nettype none

module bpc_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire bpc_pkg::item_t q_item,
    input  wire logic [1:0]     oss,
    input  wire logic [47:0]    ac123,
    input  wire logic [47:0]    ac456,
    input  wire logic [31:0]    b12,
    input  wire logic [31:0]    mcmd,
    output logic                o_valid,
    input  wire logic           o_ready,
    output logic [31:0]         o_temp,
    output logic [31:0]         o_pres,
    output logic                o_err
);

    bpc_pkg::state_t st_reg, st_next;
    logic [4:0]  pc_reg, pc_next;
    logic [31:0] x1_reg, x1_next, x2_reg, x2_next, x3_reg, x3_next;
    logic [31:0] b3_reg, b3_next, b4_reg, b4_next, b5_reg, b5_next;
    logic [31:0] b6_reg, b6_next, sq_reg, sq_next, p_reg, p_next;
    logic [31:0] t_reg, t_next, dn_reg, dn_next, dd_reg, dd_next;
    logic        neg_reg, neg_next;
    logic [15:0] ut_reg, ut_next;
    logic [18:0] up_reg, up_next;
    logic [31:0] tw_reg, tw_next;
    logic        ew_reg, ew_next;
    logic [31:0] tout_reg, tout_next, pout_reg, pout_next;
    logic        err_reg, err_next, ov_reg, ov_next;
    logic        dstart;
    logic        ddone;
    logic [31:0] dquo;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, t32, t33;

    assign ac1 = {{16{ac123[47]}}, ac123[47:32]};
    assign ac2 = {{16{ac123[31]}}, ac123[31:16]};
    assign ac3 = {{16{ac123[15]}}, ac123[15:0]};
    assign ac4 = {16'd0, ac456[47:32]};
    assign ac5 = {16'd0, ac456[31:16]};
    assign ac6 = {16'd0, ac456[15:0]};
    assign b1  = {{16{b12[31]}}, b12[31:16]};
    assign b2  = {{16{b12[15]}}, b12[15:0]};
    assign mc  = {{16{mcmd[31]}}, mcmd[31:16]};
    assign md  = {{16{mcmd[15]}}, mcmd[15:0]};

    // The divider loads the operands prepared in the same step.
    bpc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dstart),
        .dividend (dn_next),
        .divisor  (dd_next),
        .done     (ddone),
        .quotient (dquo)
    );

    // Sequencer: each program step does one multiply or add on registers.
    always_comb begin
        st_next = st_reg; pc_next = pc_reg;
        x1_next = x1_reg; x2_next = x2_reg; x3_next = x3_reg;
        b3_next = b3_reg; b4_next = b4_reg; b5_next = b5_reg;
        b6_next = b6_reg; sq_next = sq_reg; p_next = p_reg; t_next = t_reg;
        dn_next = dn_reg; dd_next = dd_reg; neg_next = neg_reg;
        ut_next = ut_reg; up_next = up_reg;
        tw_next = tw_reg; ew_next = ew_reg;
        tout_next = tout_reg; pout_next = pout_reg; err_next = err_reg;
        ov_next = ov_reg;
        q_pop = 1'b0; dstart = 1'b0;
        t32 = '0; t33 = '0;
        if (ov_reg && o_ready) begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            bpc_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop   = 1'b1;
                    ut_next = q_item.ut;
                    up_next = q_item.up;
                    pc_next = '0;
                    st_next = bpc_pkg::ST_MATH;
                end
            end
            bpc_pkg::ST_MATH: begin
                pc_next = pc_reg + 5'd1;
                unique case (pc_reg)
                    5'd0: t_next = ({16'd0, ut_reg} - ac6) * ac5;
                    5'd1: begin
                        x1_next = $signed(t_reg) >>> 15;
                        dn_next = mc << 11;
                    end
                    5'd2: dd_next = x1_reg + md;
                    5'd3: begin
                        if (dd_reg == 32'd0) begin
                            tw_next = '0; p_next = '0; ew_next = 1'b1;
                            st_next = bpc_pkg::ST_DONE;
                        end else begin
                            neg_next = dn_reg[31] ^ dd_reg[31];
                            dn_next  = dn_reg[31] ? -dn_reg : dn_reg;
                            dd_next  = dd_reg[31] ? -dd_reg : dd_reg;
                            st_next  = bpc_pkg::ST_DIV;
                        end
                    end
                    5'd4: begin
                        b5_next = x1_reg + (neg_reg ? -dquo : dquo);
                    end
                    5'd5: begin
                        tw_next = $signed(b5_reg + 32'd8) >>> 4;
                        b6_next = b5_reg - bpc_pkg::C_B6_OFS;
                    end
                    5'd6: t_next = b6_reg * b6_reg;
                    5'd7: sq_next = $signed(t_reg) >>> 12;
                    5'd8: t_next = b2 * sq_reg;
                    5'd9: begin
                        x1_next = $signed(t_reg) >>> 11;
                        t_next  = ac2 * b6_reg;
                    end
                    5'd10: begin
                        t32     = $signed(t_reg) >>> 11;
                        x3_next = x1_reg + t32;
                    end
                    5'd11: begin
                        t32 = ((ac1 * 32'd4 + x3_reg) << oss) + 32'd2;
                        // Divide by four truncating toward zero.
                        t33 = t32[31] ? (t32 + 32'd3) : t32;
                        b3_next = $signed(t33) >>> 2;
                    end
                    5'd12: t_next = ac3 * b6_reg;
                    5'd13: begin
                        x1_next = $signed(t_reg) >>> 13;
                        t_next  = b1 * sq_reg;
                    end
                    5'd14: begin
                        x2_next = $signed(t_reg) >>> 16;
                    end
                    5'd15: x3_next = $signed(x1_reg + x2_reg + 32'd2) >>> 2;
                    5'd16: t_next = ac4 * (x3_reg + bpc_pkg::C_HALF);
                    5'd17: begin
                        b4_next = t_reg >> 15;
                        t_next  = ({13'd0, up_reg} - b3_reg)
                                  * (bpc_pkg::C_SCALE >> oss);
                    end
                    5'd18: begin
                        if (b4_reg == 32'd0) begin
                            p_next = '0; ew_next = 1'b1;
                            st_next = bpc_pkg::ST_DONE;
                        end else begin
                            dn_next  = t_reg[31] ? t_reg : (t_reg << 1);
                            neg_next = t_reg[31];
                            dd_next  = b4_reg;
                            st_next  = bpc_pkg::ST_DIV;
                        end
                    end
                    5'd19: begin
                        p_next = neg_reg ? (dquo << 1) : dquo;
                    end
                    5'd20: begin
                        x1_next = $signed(p_reg) >>> 8;
                        t_next  = bpc_pkg::C_P_K2 * p_reg;
                    end
                    5'd21: begin
                        x1_next = x1_reg * x1_reg;
                        x2_next = $signed(t_reg) >>> 16;
                    end
                    5'd22: t_next = x1_reg * bpc_pkg::C_P_K1;
                    5'd23: begin
                        x1_next = $signed(t_reg) >>> 16;
                    end
                    default: begin
                        t32     = $signed(x1_reg + x2_reg + bpc_pkg::C_P_K3) >>> 4;
                        p_next  = p_reg + t32;
                        ew_next = 1'b0;
                        st_next = bpc_pkg::ST_DONE;
                    end
                endcase
                if (pc_reg == 5'd3 && dd_reg != 32'd0) begin
                    dstart = 1'b1;
                end
                if (pc_reg == 5'd18 && b4_reg != 32'd0) begin
                    dstart = 1'b1;
                end
            end
            bpc_pkg::ST_DIV: begin
                if (ddone) begin
                    st_next = bpc_pkg::ST_MATH;
                end
            end
            bpc_pkg::ST_DONE: begin
                // Load the output register once it is free.
                if (!ov_next) begin
                    tout_next = tw_reg;
                    pout_next = p_reg;
                    err_next  = ew_reg;
                    ov_next   = 1'b1;
                    st_next   = bpc_pkg::ST_IDLE;
                end
            end
            default: st_next = bpc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= bpc_pkg::ST_IDLE;
            pc_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            pc_reg <= pc_next;
            ov_reg <= ov_next;
        end
        x1_reg <= x1_next; x2_reg <= x2_next; x3_reg <= x3_next;
        b3_reg <= b3_next; b4_reg <= b4_next; b5_reg <= b5_next;
        b6_reg <= b6_next; sq_reg <= sq_next; p_reg <= p_next; t_reg <= t_next;
        dn_reg <= dn_next; dd_reg <= dd_next; neg_reg <= neg_next;
        ut_reg <= ut_next; up_reg <= up_next;
        tw_reg <= tw_next; ew_reg <= ew_next;
        tout_reg <= tout_next; pout_reg <= pout_next; err_reg <= err_next;
    end

    assign o_valid = ov_reg;
    assign o_temp  = tout_reg;
    assign o_pres  = pout_reg;
    assign o_err   = err_reg;

    // A result stays until taken, and the divider only runs while waited on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !o_ready) |=> ov_reg && $stable(tout_reg) && $stable(pout_reg))
        else $error("pending result changed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        dstart |=> st_reg == bpc_pkg::ST_DIV)
        else $error("divider started outside divide wait");
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> st_reg == bpc_pkg::ST_IDLE)
        else $error("item taken while busy");

endmodule

`default_nettype wire

// File: hdl/baro_pressure_temp_compensation.sv
// ============================================================================
// baro_pressure_temp_compensation: integer temperature/pressure compensation
// Turns raw sensor words into tenths of a degree and pascals.
// ============================================================================
//  channel   direction  tdata (low to high)                      tuser
//  s_        in         raw_temperature[15:0], raw_pressure[34:16] -
//  m_        out        temperature_tenths, pressure_pa            divide_error
//  cfg_      in         index 0..4, data up to 48 bits             -
//
// When no divisor is zero, an item is taken from the queue, runs through 25
// sequencer steps and two waits on the serial divider (32 steps and the done
// strobe each) and is then loaded into the output register.
// A two-entry queue takes items while the sequencer works; a result waits
// in the output register, and the sequencer stalls only when a second result
// is ready before the first transfer.
// Reset is synchronous, active low, and clears all configuration to zero.
// ============================================================================
`default_nettype none

module baro_pressure_temp_compensation (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // raw_temperature, raw_pressure
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,  // temperature_tenths, pressure_pa
    output logic             m_tuser,  // divide_error
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    logic [1:0]     oss_reg;
    logic [47:0]    ac123_reg, ac456_reg;
    logic [31:0]    b12_reg, mcmd_reg;
    logic           q_valid, q_pop;
    bpc_pkg::item_t in_item, q_item;
    logic [31:0]    temp, pres;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oss_reg <= '0; ac123_reg <= '0; ac456_reg <= '0;
            b12_reg <= '0; mcmd_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bpc_pkg::REG_OSS:   oss_reg   <= cfg_data[1:0];
                bpc_pkg::REG_AC123: ac123_reg <= cfg_data;
                bpc_pkg::REG_AC456: ac456_reg <= cfg_data;
                bpc_pkg::REG_B12:   b12_reg   <= cfg_data[31:0];
                bpc_pkg::REG_MCMD:  mcmd_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign in_item.ut = s_tdata[15:0];
    assign in_item.up = s_tdata[34:16];

    bpc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    bpc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .oss     (oss_reg),
        .ac123   (ac123_reg),
        .ac456   (ac456_reg),
        .b12     (b12_reg),
        .mcmd    (mcmd_reg),
        .o_valid (m_tvalid),
        .o_ready (m_tready),
        .o_temp  (temp),
        .o_pres  (pres),
        .o_err   (m_tuser)
    );

    assign m_tdata = {pres, temp};

endmodule

`default_nettype wire
